FILE: sv/lkd_pkg.sv
// Package for the LED display and key controller slave.
// Holds item types, the controller state struct and command constants; no dependencies.
`default_nettype none

package lkd_pkg;

  // bus event codes
  localparam logic [1:0] OP_FRAME_START = 2'd0;
  localparam logic [1:0] OP_WRITE_BYTE  = 2'd1;
  localparam logic [1:0] OP_READ_BYTE   = 2'd2;
  localparam logic [1:0] OP_FRAME_END   = 2'd3;

  // command byte fields
  localparam logic [7:0] CMD_KIND_MASK  = 8'hC0;
  localparam logic [7:0] CMD_DATA       = 8'h40;
  localparam logic [7:0] CMD_CONTROL    = 8'h80;
  localparam logic [7:0] CMD_ADDRESS    = 8'hC0;
  localparam logic [7:0] CTRL_ON_BIT    = 8'h08;
  localparam logic [7:0] DATA_READ_BIT  = 8'h02;
  localparam logic [7:0] DATA_FIXED_BIT = 8'h04;

  localparam logic [7:0] IDLE_READ_BYTE = 8'hFF;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  write_byte;
    logic [31:0] key_scan;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       ram_write;
    logic [3:0] ram_address;
    logic [7:0] ram_data;
    logic       display_on;
    logic [2:0] brightness;
  } out_item_t;

  typedef struct packed {
    logic [3:0] address_pointer;
    logic       fixed_address_mode;
    logic       key_read_mode;
    logic       expect_command;
    logic [1:0] key_byte_index;
    logic       enable_flag;
    logic [2:0] brightness_level;
    logic       data_phase;
  } ctrl_state_t;

endpackage

`default_nettype wire

FILE: sv/lkd_chan.sv
// Valid/ready channel interface carrying one item per handshake.
// Payload type is a parameter; used with lkd_pkg item types.
`default_nettype none

interface lkd_chan #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/led_key_display_controller_top.sv
// The result of an accepted item is registered and valid in the cycle after it is taken.
// Throughput: one item per cycle; the result register frees as it drains,
// so a new item is taken whenever the result is empty or being taken.
// Display memory writes are reported on the ram fields of each result.
// Reset (rst, synchronous) clears the controller state and the result valid.
`default_nettype none

module led_key_display_controller_top #(
  parameter int RAM_DEPTH = 16,
  parameter int KEY_BYTES = 4
) (
  input wire logic clk,
  input wire logic rst,
  lkd_chan.sink    items,
  lkd_chan.source  results
);
  import lkd_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  out_item_t   result_next;
  out_item_t   result;
  logic        result_valid;
  logic        accept;

  assign items.ready = !result_valid || results.ready;
  assign accept      = items.valid && items.ready;

  lkd_decode #(
    .RAM_DEPTH(RAM_DEPTH),
    .KEY_BYTES(KEY_BYTES)
  ) u_decode (
    .item      (items.data),
    .state     (state),
    .state_next(state_next),
    .result    (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        state <= state_next;
      end
      if (accept) begin
        result_valid <= 1'b1;
      end else if (results.ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  assign results.valid = result_valid;
  assign results.data  = result;

endmodule

`default_nettype wire

FILE: sv/lkd_decode.sv
// Command decode and next-state logic for one bus event.
// Depends on lkd_pkg for item and state types and command constants.
`default_nettype none

module lkd_decode #(
  parameter int RAM_DEPTH = 16,
  parameter int KEY_BYTES = 4
) (
  input  lkd_pkg::in_item_t    item,
  input  lkd_pkg::ctrl_state_t state,
  output lkd_pkg::ctrl_state_t state_next,
  output lkd_pkg::out_item_t   result
);
  import lkd_pkg::*;

  localparam logic [4:0] DEPTH = 5'(RAM_DEPTH);
  localparam logic [2:0] KEYS  = 3'(KEY_BYTES);

  logic [7:0] cmd_kind;
  logic [4:0] cmd_addr;
  logic [3:0] cmd_addr_wrap;
  logic [4:0] ptr_inc;
  logic [3:0] ptr_inc_wrap;
  logic [1:0] key_sel;
  logic [2:0] key_inc;
  logic [1:0] key_idx_next;
  logic [7:0] key_byte;

  assign cmd_kind = item.write_byte & CMD_KIND_MASK;

  // address modulo depth: value stays below twice the depth
  assign cmd_addr      = {1'b0, item.write_byte[3:0]};
  assign cmd_addr_wrap = (cmd_addr >= DEPTH) ? 4'(cmd_addr - DEPTH) : cmd_addr[3:0];

  assign ptr_inc      = {1'b0, state.address_pointer} + 5'd1;
  assign ptr_inc_wrap = (ptr_inc >= DEPTH) ? 4'd0 : ptr_inc[3:0];

  assign key_sel      = ({1'b0, state.key_byte_index} >= KEYS) ? 2'd0 : state.key_byte_index;
  assign key_inc      = {1'b0, key_sel} + 3'd1;
  assign key_idx_next = (key_inc >= KEYS) ? 2'd0 : key_inc[1:0];

  always_comb begin
    case (key_sel)
      2'd0:    key_byte = item.key_scan[7:0];
      2'd1:    key_byte = item.key_scan[15:8];
      2'd2:    key_byte = item.key_scan[23:16];
      default: key_byte = item.key_scan[31:24];
    endcase
  end

  always_comb begin
    state_next         = state;
    result.read_data   = IDLE_READ_BYTE;
    result.ram_write   = 1'b0;
    result.ram_address = 4'd0;
    result.ram_data    = 8'd0;
    case (item.operation)
      OP_FRAME_START: begin
        state_next.expect_command = 1'b1;
        state_next.data_phase     = 1'b0;
        state_next.key_byte_index = 2'd0;
      end
      OP_FRAME_END: begin
        state_next.expect_command = 1'b0;
        state_next.data_phase     = 1'b0;
      end
      OP_WRITE_BYTE: begin
        if (state.expect_command) begin
          state_next.expect_command = 1'b0;
          if (cmd_kind == CMD_DATA) begin
            state_next.key_read_mode      = |(item.write_byte & DATA_READ_BIT);
            state_next.fixed_address_mode = |(item.write_byte & DATA_FIXED_BIT);
          end else if (cmd_kind == CMD_CONTROL) begin
            state_next.enable_flag      = |(item.write_byte & CTRL_ON_BIT);
            state_next.brightness_level = item.write_byte[2:0];
          end else if (cmd_kind == CMD_ADDRESS) begin
            state_next.address_pointer = cmd_addr_wrap;
            state_next.data_phase      = 1'b1;
          end
        end else if (state.data_phase) begin
          result.ram_write   = 1'b1;
          result.ram_address = state.address_pointer;
          result.ram_data    = item.write_byte;
          if (!state.fixed_address_mode) begin
            state_next.address_pointer = ptr_inc_wrap;
          end
        end
      end
      default: begin
        if (state.key_read_mode) begin
          result.read_data          = key_byte;
          state_next.key_byte_index = key_idx_next;
        end
      end
    endcase
    result.display_on = state_next.enable_flag;
    result.brightness = state_next.brightness_level;
  end

endmodule

`default_nettype wire

FILE: sv/lkd_checker.sv
// Port-level checks for the LED display and key controller top level.
// Depends on lkd_pkg; bound to led_key_display_controller_top below.
`default_nettype none

module lkd_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire lkd_pkg::out_item_t out_data
);
  import lkd_pkg::*;

  // every accepted item shows a result in the next cycle
  a_item_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item produced no result");

  // an empty result register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // no memory write means zero address and data
  a_idle_write_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.ram_write |-> out_data.ram_address == 4'd0 &&
    out_data.ram_data == 8'd0)
    else $error("write fields set without a memory write");

  // a written byte is never also a read byte
  a_write_not_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.ram_write |-> out_data.read_data == IDLE_READ_BYTE)
    else $error("write item returned read data");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind led_key_display_controller_top lkd_checker u_lkd_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (items.valid),
  .in_ready (items.ready),
  .out_valid(results.valid),
  .out_ready(results.ready),
  .out_data (results.data)
);

`default_nettype wire
